// ----- sv/rtphp_pkg.sv -----
// ----------------------------------------------------------------------------
// rtphp_pkg
// Shared types and constants for the RTP fixed header parser.
// ----------------------------------------------------------------------------
package rtphp_pkg;

  localparam int MAX_PACKET_BYTES = 2048;
  // Byte counter must hold MAX_PACKET_BYTES itself.
  localparam int POS_W = $clog2(MAX_PACKET_BYTES + 1);
  localparam int CMP_W = (POS_W > 8) ? POS_W : 8;
  localparam int FIXED_LEN = 12;
  localparam int HDR_W = 7;

  typedef enum logic [1:0] {
    KIND_HEADER = 2'd0,
    KIND_CSRC   = 2'd1,
    KIND_END    = 2'd2
  } rtp_kind_t;

  typedef enum logic [1:0] {
    STATUS_OK      = 2'd0,
    STATUS_SHORT   = 2'd1,
    STATUS_PAD_BAD = 2'd2
  } rtp_status_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } rtp_in_t;

  typedef struct packed {
    rtp_kind_t   kind;
    logic        marker;
    logic [6:0]  pt_code;
    logic [15:0] sequence_res;
    logic [31:0] timestamp;
    logic [31:0] word;
    logic [3:0]  csrc_count;
    logic        extension_flag;
    logic        padding_flag;
    logic [7:0]  pad_count;
    rtp_status_t status;
    logic        last;
  } rtp_out_t;

endpackage

// ----- sv/rtp_fixed_header_parser.sv -----
// ----------------------------------------------------------------------------
// rtp_fixed_header_parser
// Parses the RTP fixed header and CSRC list from a byte stream, one byte per
// cycle while byte_stall is low; reports header, CSRC and end-of-packet words.
//
// Usage:
//   Input channel (byte_valid/byte_stall/byte_data) carries one packet byte
//   per word with a last-byte flag. Output channel (res_valid/res_stall/
//   res_data) carries result words: a header word on byte 11, one word per
//   CSRC, and an end word on the last byte.
//   Each result is written into the result queue when its byte is accepted.
//   Throughput: one byte per cycle while byte_stall is low. A byte that
//   yields two results (last byte completing a header or CSRC) puts both
//   into a four-entry result queue, which drains one word per cycle while
//   res_stall is low. byte_stall rises when fewer than two queue entries are
//   free; it tracks the registered entry count, so nothing is dropped.
//   cfg_we/cfg_data write the padding-ignore bit; write only while idle.
//   Reset clears the parse state, the queue and the padding-ignore bit.
// ----------------------------------------------------------------------------
module rtp_fixed_header_parser
  import rtphp_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     byte_valid,
  output logic     byte_stall,
  input  rtp_in_t  byte_data,
  output logic     res_valid,
  input  logic     res_stall,
  output rtp_out_t res_data,
  input  logic     cfg_we,
  input  logic     cfg_data
);

  localparam logic [POS_W-1:0] POS_MAX = POS_W'(MAX_PACKET_BYTES);

  logic             pad_ignore;
  logic [POS_W-1:0] byte_position;
  logic [3:0]       announced_csrcs;
  logic             padding_bit;
  logic             extension_bit;
  logic             marker_bit;
  logic [6:0]       kept_payload_type;
  logic [15:0]      kept_sequence;
  logic [31:0]      kept_timestamp;
  logic [31:0]      word_assembly;

  logic [POS_W-1:0] byte_position_next;
  logic [3:0]       announced_csrcs_next;
  logic             padding_bit_next;
  logic             extension_bit_next;
  logic             marker_bit_next;
  logic [6:0]       kept_payload_type_next;
  logic [15:0]      kept_sequence_next;
  logic [31:0]      kept_timestamp_next;
  logic [31:0]      word_assembly_next;

  // result queue
  rtp_out_t   queue [4];
  logic [1:0] rd_ptr;
  logic [1:0] wr_ptr;
  logic [2:0] count;

  logic       accept;
  logic       pop;
  logic [7:0] b;
  logic       in_range;
  logic [HDR_W-1:0] hdr_len_cur;
  logic [HDR_W-1:0] hdr_len_end;
  logic       in_words;
  logic       emit_word;
  rtp_kind_t  word_kind;
  logic [POS_W-1:0] len;
  logic [POS_W-1:0] remain;
  logic [7:0]       pad_len;
  rtp_status_t      end_status;
  rtp_out_t   word_res;
  rtp_out_t   end_res;
  rtp_out_t   first_res;
  logic [1:0] push_cnt;

  assign accept     = byte_valid && !byte_stall;
  assign pop        = res_valid && !res_stall;
  assign byte_stall = (count > 3'd2);
  assign res_valid  = (count != 3'd0);
  assign res_data   = queue[rd_ptr];

  assign b           = byte_data.data_byte;
  assign in_range    = (byte_position < POS_MAX);
  assign hdr_len_cur = HDR_W'(FIXED_LEN) + {1'b0, announced_csrcs, 2'b00};
  assign in_words    = (byte_position >= POS_W'(8)) &&
                       (byte_position < POS_W'(hdr_len_cur));

  always_comb begin
    announced_csrcs_next   = announced_csrcs;
    padding_bit_next       = padding_bit;
    extension_bit_next     = extension_bit;
    marker_bit_next        = marker_bit;
    kept_payload_type_next = kept_payload_type;
    kept_sequence_next     = kept_sequence;
    kept_timestamp_next    = kept_timestamp;
    word_assembly_next     = word_assembly;
    emit_word              = 1'b0;
    word_kind              = KIND_HEADER;
    if (in_range) begin
      if (byte_position == '0) begin
        padding_bit_next     = b[5];
        extension_bit_next   = b[4];
        announced_csrcs_next = b[3:0];
      end else if (byte_position == POS_W'(1)) begin
        marker_bit_next        = b[7];
        kept_payload_type_next = b[6:0];
      end else if (byte_position < POS_W'(4)) begin
        kept_sequence_next = {kept_sequence[7:0], b};
      end else if (byte_position < POS_W'(8)) begin
        kept_timestamp_next = {kept_timestamp[23:0], b};
      end else if (in_words) begin
        word_assembly_next = {word_assembly[23:0], b};
        if (byte_position == POS_W'(FIXED_LEN - 1)) begin
          emit_word = 1'b1;
          word_kind = KIND_HEADER;
        end else if (byte_position >= POS_W'(FIXED_LEN) &&
                     byte_position[1:0] == 2'd3) begin
          // CSRC list starts on a word boundary: low bits mark the fourth byte
          emit_word = 1'b1;
          word_kind = KIND_CSRC;
        end
      end
      byte_position_next = byte_position + POS_W'(1);
    end else begin
      byte_position_next = byte_position;
    end
  end

  // end-of-packet checks use the length after this byte
  assign len         = byte_position_next;
  assign hdr_len_end = HDR_W'(FIXED_LEN) + {1'b0, announced_csrcs_next, 2'b00};
  assign remain      = len - POS_W'(hdr_len_end);

  always_comb begin
    pad_len    = 8'd0;
    end_status = STATUS_OK;
    if (len < POS_W'(hdr_len_end)) begin
      end_status = STATUS_SHORT;
    end else if (padding_bit_next && !pad_ignore &&
                 len > POS_W'(hdr_len_end)) begin
      pad_len = b;
      if (CMP_W'(b) > CMP_W'(remain)) begin
        end_status = STATUS_PAD_BAD;
      end
    end
  end

  always_comb begin
    word_res.kind           = word_kind;
    word_res.marker         = marker_bit;
    word_res.pt_code        = kept_payload_type;
    word_res.sequence_res   = kept_sequence;
    word_res.timestamp      = kept_timestamp;
    word_res.word           = word_assembly_next;
    word_res.csrc_count     = announced_csrcs;
    word_res.extension_flag = extension_bit;
    word_res.padding_flag   = padding_bit;
    word_res.pad_count      = 8'd0;
    word_res.status         = STATUS_OK;
    word_res.last           = 1'b0;

    end_res.kind           = KIND_END;
    end_res.marker         = 1'b0;
    end_res.pt_code        = 7'd0;
    end_res.sequence_res   = 16'd0;
    end_res.timestamp      = 32'd0;
    end_res.word           = 32'd0;
    end_res.csrc_count     = announced_csrcs_next;
    end_res.extension_flag = extension_bit_next;
    end_res.padding_flag   = padding_bit_next;
    end_res.pad_count      = pad_len;
    end_res.status         = end_status;
    end_res.last           = 1'b1;

    first_res = emit_word ? word_res : end_res;
    push_cnt  = 2'({1'b0, emit_word} + {1'b0, byte_data.last_byte});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pad_ignore        <= 1'b0;
      byte_position     <= '0;
      announced_csrcs   <= 4'd0;
      padding_bit       <= 1'b0;
      extension_bit     <= 1'b0;
      marker_bit        <= 1'b0;
      kept_payload_type <= 7'd0;
      kept_sequence     <= 16'd0;
      kept_timestamp    <= 32'd0;
      word_assembly     <= 32'd0;
      rd_ptr            <= 2'd0;
      wr_ptr            <= 2'd0;
      count             <= 3'd0;
    end else begin
      if (cfg_we) begin
        pad_ignore <= cfg_data;
      end
      if (accept) begin
        announced_csrcs   <= announced_csrcs_next;
        padding_bit       <= padding_bit_next;
        extension_bit     <= extension_bit_next;
        marker_bit        <= marker_bit_next;
        kept_payload_type <= kept_payload_type_next;
        kept_sequence     <= kept_sequence_next;
        kept_timestamp    <= kept_timestamp_next;
        word_assembly     <= word_assembly_next;
        // restart the count after the last byte
        byte_position     <= byte_data.last_byte ? '0 : byte_position_next;
        wr_ptr            <= wr_ptr + push_cnt;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 2'd1;
      end
      count <= count + (accept ? {1'b0, push_cnt} : 3'd0) - (pop ? 3'd1 : 3'd0);
    end
  end

  always_ff @(posedge clk) begin
    if (accept && push_cnt != 2'd0) begin
      queue[wr_ptr] <= first_res;
    end
    if (accept && push_cnt == 2'd2) begin
      queue[wr_ptr + 2'd1] <= end_res;
    end
  end

endmodule

// ----- verif/rtp_parse_checker.sv -----
// ----------------------------------------------------------------------------
// rtp_parse_checker
// Watches the byte and result channels of the RTP fixed header parser. It
// parses every accepted byte with its own copy of the header state, queues
// the result words that byte must cause, and compares each accepted result
// word field by field with the oldest queued one.
// ----------------------------------------------------------------------------
module rtp_parse_checker
  import rtphp_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     byte_valid,
  input  logic     byte_stall,
  input  rtp_in_t  byte_data,
  input  logic     res_valid,
  input  logic     res_stall,
  input  rtp_out_t res_data,
  input  logic     cfg_we,
  input  logic     cfg_data,
  output int       outstanding,
  output int       failures,
  output int       packets_seen,
  output int       words_checked,
  output int       short_ends,
  output int       bad_pad_ends
);

  rtp_out_t parsed_words[$];
  int       err_cnt   = 0;
  int       pkt_cnt   = 0;
  int       word_cnt  = 0;
  int       short_cnt = 0;
  int       bad_cnt   = 0;

  logic                 ignore_pad;
  logic [POS_W-1:0]     pos_cnt;
  logic [3:0]           csrc_cnt;
  logic                 pad_bit;
  logic                 ext_bit;
  logic                 mark_bit;
  logic [6:0]           pt_kept;
  logic [15:0]          seq_kept;
  logic [31:0]          ts_kept;
  logic [31:0]          word_acc;

  function automatic rtp_out_t result_word(rtp_kind_t k, logic [31:0] w,
                                           logic [7:0] plen, rtp_status_t st);
    rtp_out_t r;
    logic     at_end;
    at_end           = (k == KIND_END);
    r.kind           = k;
    r.marker         = at_end ? 1'b0 : mark_bit;
    r.pt_code        = at_end ? 7'd0 : pt_kept;
    r.sequence_res   = at_end ? 16'd0 : seq_kept;
    r.timestamp      = at_end ? 32'd0 : ts_kept;
    r.word           = w;
    r.csrc_count     = csrc_cnt;
    r.extension_flag = ext_bit;
    r.padding_flag   = pad_bit;
    r.pad_count      = plen;
    r.status         = st;
    r.last           = at_end;
    return r;
  endfunction

  task automatic parse_byte(input rtp_in_t in);
    int          idx;
    int          hdr_len;
    int          len;
    logic [7:0]  b;
    logic [7:0]  plen;
    rtp_status_t st;
    b   = in.data_byte;
    idx = int'(pos_cnt);
    if (idx < MAX_PACKET_BYTES) begin
      if (idx == 0) begin
        pad_bit  = b[5];
        ext_bit  = b[4];
        csrc_cnt = b[3:0];
      end else if (idx == 1) begin
        mark_bit = b[7];
        pt_kept  = b[6:0];
      end else if (idx < 4) begin
        seq_kept = {seq_kept[7:0], b};
      end else if (idx < 8) begin
        ts_kept = {ts_kept[23:0], b};
      end else if (idx < FIXED_LEN + 4 * int'(csrc_cnt)) begin
        word_acc = {word_acc[23:0], b};
        if (idx == FIXED_LEN - 1)
          parsed_words.push_back(result_word(KIND_HEADER, word_acc, 8'd0, STATUS_OK));
        else if (idx >= FIXED_LEN && ((idx - FIXED_LEN) % 4) == 3)
          parsed_words.push_back(result_word(KIND_CSRC, word_acc, 8'd0, STATUS_OK));
      end
      pos_cnt = POS_W'(idx + 1);
    end
    if (in.last_byte) begin
      len     = int'(pos_cnt);
      hdr_len = FIXED_LEN + 4 * int'(csrc_cnt);
      st      = STATUS_OK;
      plen    = 8'd0;
      if (len < hdr_len) begin
        st = STATUS_SHORT;
        short_cnt++;
      end else if (pad_bit && !ignore_pad && len > hdr_len) begin
        plen = b;
        if (int'(plen) > len - hdr_len) begin
          st = STATUS_PAD_BAD;
          bad_cnt++;
        end
      end
      parsed_words.push_back(result_word(KIND_END, 32'd0, plen, st));
      pkt_cnt++;
      pos_cnt = '0;
    end
  endtask

  task automatic compare_field(input string name, input logic [31:0] actual,
                               input logic [31:0] expected);
    if (actual !== expected) begin
      err_cnt++;
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, expected, actual);
    end
  endtask

  always @(posedge clk) begin : watch
    rtp_out_t want;
    if (rst) begin
      ignore_pad = 1'b0;
      pos_cnt    = '0;
      csrc_cnt   = '0;
      pad_bit    = 1'b0;
      ext_bit    = 1'b0;
      mark_bit   = 1'b0;
      pt_kept    = '0;
      seq_kept   = '0;
      ts_kept    = '0;
      word_acc   = '0;
      parsed_words.delete();
    end else begin
      if (cfg_we)
        ignore_pad = cfg_data;
      // compare before parsing: a word never leaves in the cycle its byte enters
      if (res_valid && !res_stall) begin
        if (parsed_words.size() == 0) begin
          err_cnt++;
          $display("%0t: unexpected result word, expected none, actual %h", $time, res_data);
        end else begin
          want = parsed_words.pop_front();
          compare_field("kind", 32'(res_data.kind), 32'(want.kind));
          compare_field("marker", 32'(res_data.marker), 32'(want.marker));
          compare_field("pt_code", 32'(res_data.pt_code), 32'(want.pt_code));
          compare_field("sequence_res", 32'(res_data.sequence_res),
                        32'(want.sequence_res));
          compare_field("timestamp", res_data.timestamp, want.timestamp);
          compare_field("word", res_data.word, want.word);
          compare_field("csrc_count", 32'(res_data.csrc_count), 32'(want.csrc_count));
          compare_field("extension_flag", 32'(res_data.extension_flag),
                        32'(want.extension_flag));
          compare_field("padding_flag", 32'(res_data.padding_flag),
                        32'(want.padding_flag));
          compare_field("pad_count", 32'(res_data.pad_count), 32'(want.pad_count));
          compare_field("status", 32'(res_data.status), 32'(want.status));
          compare_field("last", 32'(res_data.last), 32'(want.last));
          word_cnt++;
        end
      end
      if (byte_valid && !byte_stall)
        parse_byte(byte_data);
    end
    outstanding   <= parsed_words.size();
    failures      <= err_cnt;
    packets_seen  <= pkt_cnt;
    words_checked <= word_cnt;
    short_ends    <= short_cnt;
    bad_pad_ends  <= bad_cnt;
  end

endmodule

// ----- verif/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Drives RTP packets into the fixed header parser: a few hand-built packets,
// then mostly well-formed random packets mixed with runts and garbage,
// under random source gaps and sink stalls outside the quiet phase, with
// the padding-ignore bit set both ways between phases.
// ----------------------------------------------------------------------------
module tb;
  import rtphp_pkg::*;

  localparam int CYCLE_LIMIT = 200000;

  logic     clk        = 1'b0;
  logic     rst        = 1'b1;
  logic     byte_valid = 1'b0;
  logic     byte_stall;
  rtp_in_t  byte_data  = '0;
  logic     res_valid;
  logic     res_stall  = 1'b0;
  rtp_out_t res_data;
  logic     cfg_we     = 1'b0;
  logic     cfg_data   = 1'b0;
  logic     quiet      = 1'b0;
  int       cycles     = 0;

  int outstanding;
  int failures;
  int packets_seen;
  int words_checked;
  int short_ends;
  int bad_pad_ends;

  always #4 clk = ~clk;

  rtp_fixed_header_parser u_top (
    .clk        (clk),
    .rst        (rst),
    .byte_valid (byte_valid),
    .byte_stall (byte_stall),
    .byte_data  (byte_data),
    .res_valid  (res_valid),
    .res_stall  (res_stall),
    .res_data   (res_data),
    .cfg_we     (cfg_we),
    .cfg_data   (cfg_data)
  );

  rtp_parse_checker u_checker (
    .clk           (clk),
    .rst           (rst),
    .byte_valid    (byte_valid),
    .byte_stall    (byte_stall),
    .byte_data     (byte_data),
    .res_valid     (res_valid),
    .res_stall     (res_stall),
    .res_data      (res_data),
    .cfg_we        (cfg_we),
    .cfg_data      (cfg_data),
    .outstanding   (outstanding),
    .failures      (failures),
    .packets_seen  (packets_seen),
    .words_checked (words_checked),
    .short_ends    (short_ends),
    .bad_pad_ends  (bad_pad_ends)
  );

  always @(posedge clk) begin
    res_stall <= !quiet && ($urandom_range(99) < 15);
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t: run exceeded %0d cycles", $time, CYCLE_LIMIT);
      $display("Some tests failed");
      $finish;
    end
  end

  // Returns at the edge where the word is taken; valid stays up for the next one.
  task automatic send_byte(input logic [7:0] d, input logic l);
    if (!quiet && $urandom_range(99) < 15) begin
      byte_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < 30) @(posedge clk);
    end
    byte_valid <= 1'b1;
    byte_data  <= {d, l};
    @(posedge clk);
    while (byte_stall) @(posedge clk);
  endtask

  task automatic send_packet(input logic [7:0] pkt[$]);
    foreach (pkt[i]) send_byte(pkt[i], i == pkt.size() - 1);
  endtask

  task automatic drain_results();
    byte_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic set_ignore(input logic v);
    cfg_we   <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    cfg_we   <= 1'b0;
  endtask

  task automatic random_packet(output int n);
    logic [7:0] pkt[$];
    logic [7:0] b0;
    int         sel;
    int         csrc;
    int         hdr;
    int         pay;
    int         len;
    sel = $urandom_range(99);
    b0  = 8'($urandom_range(255));
    pay = 0;
    if (sel < 75) begin
      // well-formed: full header, CSRC list, short payload
      csrc    = ($urandom_range(3) == 0) ? $urandom_range(15) : $urandom_range(2);
      b0[3:0] = 4'(csrc);
      hdr     = FIXED_LEN + 4 * csrc;
      pay     = ($urandom_range(7) == 0) ? 0 : $urandom_range(16, 1);
      len     = hdr + pay;
    end else if (sel < 88) begin
      // cut off inside the header or CSRC list
      hdr = FIXED_LEN + 4 * int'(b0[3:0]);
      len = $urandom_range(hdr - 1, 1);
    end else begin
      len = $urandom_range(48, 1);
    end
    pkt.push_back(b0);
    while (pkt.size() < len) pkt.push_back(8'($urandom_range(255)));
    // pick the padding count against the bytes after the CSRC list
    if (sel < 75 && b0[5] && pay > 0) begin
      case ($urandom_range(3))
        0:       pkt[len - 1] = 8'($urandom_range(pay, 1));
        1:       pkt[len - 1] = 8'(pay);
        2:       pkt[len - 1] = 8'($urandom_range(255, pay + 1));
        default: pkt[len - 1] = 8'h00;
      endcase
    end
    send_packet(pkt);
    n = len;
  endtask

  task automatic run_random(input int target);
    int sent;
    int n;
    sent = 0;
    while (sent < target) begin
      random_packet(n);
      sent += n;
    end
  endtask

  initial begin : stimulus
    logic [7:0] pkt[$];
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    set_ignore(1'b0);

    // one-byte runt with every flag and the largest CSRC count
    pkt = '{8'hFF};
    send_packet(pkt);
    // header only, all ones after the first byte: the last byte closes the SSRC and the packet
    pkt = '{8'h20, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
            8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF};
    send_packet(pkt);
    // header zero but for the padding and extension bits, one payload byte claiming two bytes of padding
    pkt = '{8'h30, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
            8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h02};
    send_packet(pkt);

    run_random(420);
    drain_results();

    set_ignore(1'b1);
    quiet <= 1'b1;
    run_random(300);
    quiet <= 1'b0;
    drain_results();

    set_ignore(1'b0);
    run_random(330);
    drain_results();
    repeat (4) @(posedge clk);

    $display("Parsed %0d packets into %0d result words (%0d runts, %0d bad padding),",
             packets_seen, words_checked, short_ends, bad_pad_ends);
    $display("with padding honored and ignored, under source gaps and sink stalls.");
    if (failures == 0 && outstanding == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule
